### rtl/rsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared types, constants and helper functions for the rotor cipher core.
// ----------------------------------------------------------------------------
package rsc_pkg;

    // Configuration constants
    localparam int PLUG_PAIRS  = 10;
    localparam int ROTOR_SLOTS = 4;
    localparam int ALPHA       = 26;

    localparam int LOOKUPS  = 2 * ROTOR_SLOTS - 1;
    localparam int STEP_W   = $clog2(LOOKUPS);
    localparam int SLOT_W   = $clog2(ROTOR_SLOTS);
    localparam int ADDR_W   = $clog2(ROTOR_SLOTS * ALPHA);
    localparam int WIRE_DEPTH = ROTOR_SLOTS * ALPHA;

    localparam int PLUG_W   = 60;
    localparam int TYPES_W  = 12;
    localparam int CFG_W    = 60;
    localparam int CFG_IDX_W = 2;

    localparam logic [7:0] LOWER_A = 8'd97;
    localparam logic [7:0] UPPER_A = 8'd65;
    localparam logic [7:0] LOWER_Z = 8'd122;
    localparam logic [7:0] UPPER_Z = 8'd90;

    // Turnover notches per rotor type; second notch only where flagged
    localparam logic [4:0] NOTCH_A [8] = '{5'd23, 5'd22, 5'd17, 5'd20,
                                          5'd25, 5'd12, 5'd0,  5'd16};
    localparam logic [4:0] NOTCH_B [8] = '{5'd0,  5'd0,  5'd0,  5'd0,
                                          5'd0,  5'd18, 5'd16, 5'd20};
    localparam logic [7:0] HAS_NOTCH_B = 8'b1110_0000;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PLUG_FIRST  = 2'd0,
        CFG_PLUG_SECOND = 2'd1,
        CFG_ROTOR_TYPES = 2'd2,
        CFG_UNUSED      = 2'd3
    } t_cfg_idx;

    // Input item kinds
    typedef enum logic [1:0] {
        KIND_CIPHER = 2'd0,
        KIND_WIRE   = 2'd1,
        KIND_POS    = 2'd2,
        KIND_NOP    = 2'd3
    } t_kind;

    // Result status codes
    typedef enum logic [1:0] {
        ST_CIPHER = 2'd0,
        ST_PASS   = 2'd1,
        ST_END    = 2'd2,
        ST_SETUP  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_LOOK,
        S_FINAL,
        S_EMIT
    } t_state;

    typedef logic [SLOT_W-1:0] t_slot;

    // Controller to datapath commands
    typedef struct packed {
        logic  capture;      // latch input transaction
        logic  setup_wr;     // perform wiring / position write
        logic  load_idx;     // load plugboard-swapped letter index
        logic  rd_issue;     // issue wiring table read
        logic  rd_first;     // read source is the loaded index
        t_slot rd_slot;      // slot of this lookup
        logic  emit;         // load output register
        logic  emit_cipher;  // output is a ciphertext letter; step rotors
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_cipher;     // captured item is a letter to encipher
        logic out_free;      // output register can take a result
    } t_dp_stat;

    // Reduce a value below 52 modulo 26
    function automatic logic [4:0] mod_alpha(input logic [5:0] v);
        logic [5:0] r;
        r = (v >= 6'(ALPHA)) ? v - 6'(ALPHA) : v;
        return r[4:0];
    endfunction

    // Plugboard: first valid pair containing the letter wins
    function automatic logic [4:0] plug_swap(input logic [4:0]        idx,
                                             input logic [PLUG_W-1:0] first,
                                             input logic [PLUG_W-1:0] second);
        logic [4:0] r;
        logic       hit;
        logic [5:0] a;
        logic [5:0] b;
        r   = idx;
        hit = 1'b0;
        for (int i = 0; i < PLUG_PAIRS; i++) begin
            a = first[6*i +: 6];
            b = second[6*i +: 6];
            if (!hit && a < 6'(ALPHA) && b < 6'(ALPHA)) begin
                if ({1'b0, idx} == a) begin
                    r   = b[4:0];
                    hit = 1'b1;
                end else if ({1'b0, idx} == b) begin
                    r   = a[4:0];
                    hit = 1'b1;
                end
            end
        end
        return r;
    endfunction

    function automatic logic is_notch(input logic [2:0] rtype, input logic [4:0] p);
        return (p == NOTCH_A[rtype]) || (HAS_NOTCH_B[rtype] && p == NOTCH_B[rtype]);
    endfunction

    // Slot visited at a given lookup: forward to the last slot, then back
    function automatic t_slot lookup_slot(input logic [STEP_W-1:0] step);
        int s;
        int r;
        s = int'(step);
        r = (s < ROTOR_SLOTS) ? s : (2 * ROTOR_SLOTS - 2 - s);
        return SLOT_W'(r);
    endfunction

    function automatic logic [ADDR_W-1:0] slot_base(input logic [1:0] slot);
        return ADDR_W'(slot) * ADDR_W'(ALPHA);
    endfunction

endpackage

### rtl/rsc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsc_ctrl
// Sequencer: accepts a transaction, walks the wiring lookups, emits result.
// ----------------------------------------------------------------------------
module rsc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  rsc_pkg::t_dp_stat i_stat,
    output rsc_pkg::t_dp_cmd  o_cmd
);
    import rsc_pkg::*;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.rd_slot = lookup_slot(r_step);
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.is_cipher) begin
                    o_cmd.load_idx = 1'b1;
                    n_step         = '0;
                    n_state        = S_LOOK;
                end else begin
                    o_cmd.setup_wr = 1'b1;
                    n_state        = S_EMIT;
                end
            end
            S_LOOK: begin
                o_cmd.rd_issue = 1'b1;
                o_cmd.rd_first = (r_step == '0);
                if (r_step == STEP_W'(LOOKUPS - 1)) begin
                    n_state = S_FINAL;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_FINAL: begin
                if (i_stat.out_free) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_cipher = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

### rtl/rsc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsc_datapath
// Configuration, plugboard, wiring table memory, positions and output register.
// ----------------------------------------------------------------------------
module rsc_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_we,
    input  logic [rsc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rsc_pkg::CFG_W-1:0]      i_cfg_wdata,
    // input payload
    input  logic [1:0]                     i_kind,
    input  logic [7:0]                     i_letter,
    input  logic [1:0]                     i_slot,
    input  logic [4:0]                     i_entry_index,
    input  logic [4:0]                     i_entry_value,
    // output channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [1:0]                     o_status,
    output logic [7:0]                     o_out_letter,
    // control
    input  rsc_pkg::t_dp_cmd               i_cmd,
    output rsc_pkg::t_dp_stat              o_stat
);
    import rsc_pkg::*;

    // Configuration registers
    logic [PLUG_W-1:0]  r_plug_a;
    logic [PLUG_W-1:0]  r_plug_b;
    logic [TYPES_W-1:0] r_types;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plug_a <= '1;
            r_plug_b <= '1;
            r_types  <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_PLUG_FIRST:  r_plug_a <= i_cfg_wdata[PLUG_W-1:0];
                CFG_PLUG_SECOND: r_plug_b <= i_cfg_wdata[PLUG_W-1:0];
                CFG_ROTOR_TYPES: r_types  <= i_cfg_wdata[TYPES_W-1:0];
                default: ;
            endcase
        end
    end

    // Captured transaction
    t_kind      r_kind;
    logic [7:0] r_letter;
    logic [1:0] r_slot;
    logic [4:0] r_ei;
    logic [4:0] r_ev;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind   <= t_kind'(i_kind);
            r_letter <= i_letter;
            r_slot   <= i_slot;
            r_ei     <= i_entry_index;
            r_ev     <= i_entry_value;
        end
    end

    // Letter classification
    logic       w_upper, w_lower, w_alpha, w_slot_ok;
    logic [4:0] w_letter_idx;
    t_status    w_pass_status;
    logic [7:0] w_pass_letter;

    always_comb begin
        w_upper      = (r_letter >= UPPER_A) && (r_letter <= UPPER_Z);
        w_lower      = (r_letter >= LOWER_A) && (r_letter <= LOWER_Z);
        w_alpha      = w_upper || w_lower;
        w_letter_idx = w_upper ? 5'(r_letter - UPPER_A) : 5'(r_letter - LOWER_A);
        w_slot_ok    = (int'(r_slot) < ROTOR_SLOTS);
        w_pass_status = ST_SETUP;
        w_pass_letter = 8'd0;
        if (r_kind == KIND_CIPHER) begin
            if (r_letter == 8'd0) begin
                w_pass_status = ST_END;
            end else begin
                w_pass_status = ST_PASS;
                w_pass_letter = r_letter;
            end
        end
    end

    // Slot positions
    logic [4:0] r_pos [ROTOR_SLOTS];
    logic [4:0] n_pos [ROTOR_SLOTS];
    logic       w_carry;
    logic [4:0] w_inc;

    // Stepping chain: slot 0 always steps, a notch hit carries to the next
    always_comb begin
        w_carry = 1'b1;
        w_inc   = '0;
        for (int s = 0; s < ROTOR_SLOTS; s++) begin
            n_pos[s] = r_pos[s];
            if (w_carry) begin
                w_inc    = (r_pos[s] == 5'(ALPHA - 1)) ? 5'd0 : r_pos[s] + 5'd1;
                n_pos[s] = w_inc;
                w_carry  = is_notch(r_types[3*s +: 3], w_inc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < ROTOR_SLOTS; s++) begin
                r_pos[s] <= '0;
            end
        end else if (i_cmd.emit_cipher) begin
            r_pos <= n_pos;
        end else if (i_cmd.setup_wr && r_kind == KIND_POS && w_slot_ok) begin
            r_pos[r_slot[SLOT_W-1:0]] <= mod_alpha({1'b0, r_ei});
        end
    end

    // Lookup index register
    logic [4:0] r_idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_idx) begin
            r_idx <= plug_swap(w_letter_idx, r_plug_a, r_plug_b);
        end
    end

    // Wiring table
    logic [4:0]        r_wire [WIRE_DEPTH];
    logic [4:0]        r_rd;
    logic [4:0]        w_rd_mod;
    logic [4:0]        w_src;
    logic [4:0]        w_entry;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [ADDR_W-1:0] w_wr_addr;
    logic              w_wr_en;

    always_comb begin
        w_rd_mod  = mod_alpha({1'b0, r_rd});
        w_src     = i_cmd.rd_first ? r_idx : w_rd_mod;
        w_entry   = mod_alpha({1'b0, w_src} + {1'b0, r_pos[i_cmd.rd_slot]});
        w_rd_addr = slot_base(2'(i_cmd.rd_slot)) + ADDR_W'(w_entry);
        w_wr_addr = slot_base(r_slot) + ADDR_W'(r_ei);
        w_wr_en   = i_cmd.setup_wr && r_kind == KIND_WIRE && w_slot_ok
                    && (r_ei < 5'(ALPHA));
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_wire[w_wr_addr] <= mod_alpha({1'b0, r_ev});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_issue) begin
            r_rd <= r_wire[w_rd_addr];
        end
    end

    // Output register
    logic       r_out_valid;
    t_status    r_status;
    logic [7:0] r_out_letter;
    logic [4:0] w_final_idx;

    assign w_final_idx = plug_swap(w_rd_mod, r_plug_a, r_plug_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            if (i_cmd.emit_cipher) begin
                r_status     <= ST_CIPHER;
                r_out_letter <= LOWER_A + {3'b000, w_final_idx};
            end else begin
                r_status     <= w_pass_status;
                r_out_letter <= w_pass_letter;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_out_letter = r_out_letter;

    assign o_stat.is_cipher = (r_kind == KIND_CIPHER) && w_alpha;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

endmodule

### rtl/rotor_substitution_cipher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotor_substitution_cipher_core
// Rotor-style letter cipher with plugboard, four wiring slots and stepping.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/tready         tuser kind, tdata fields
//  m_axis    out        m_axis_tvalid/tready         tuser status, tdata letter
//  cfg       in         i_cfg_we (no wait)           i_cfg_idx, i_cfg_wdata
//
//  A letter passes through capture, decode, seven dependent reads of the
//  wiring table and a final plugboard step; set-up items and pass-through
//  bytes pass through capture, decode and emit.
//  Reset is synchronous, active low; the wiring table is not cleared.
//  A held result does not block acceptance; a new result waits only
//  while the output register is still full.
// ----------------------------------------------------------------------------
module rotor_substitution_cipher_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [rsc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rsc_pkg::CFG_W-1:0]     i_cfg_wdata,
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [23:0]                   s_axis_tdata,  // letter, slot, entry_index,
                                                         // entry_value, zero pad
    input  logic [1:0]                    s_axis_tuser,  // kind
    // output stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata,  // out_letter
    output logic [1:0]                    m_axis_tuser   // status
);
    import rsc_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    rsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    rsc_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_kind        (s_axis_tuser),
        .i_letter      (s_axis_tdata[7:0]),
        .i_slot        (s_axis_tdata[9:8]),
        .i_entry_index (s_axis_tdata[14:10]),
        .i_entry_value (s_axis_tdata[19:15]),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_status      (m_axis_tuser),
        .o_out_letter  (m_axis_tdata),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat)
    );

endmodule
